@@ design/debug_run_control_defines.svh @@
// Assertion macros used by the run-control controller.
`ifndef DEBUG_RUN_CONTROL_DEFINES_SVH
`define DEBUG_RUN_CONTROL_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DBGRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("run control assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DBGRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("run control assertion failed");

`endif

@@ design/dbgrc_pkg.sv @@
`timescale 1ns / 1ps

package dbgrc_pkg;

  // Default sizes of the layer stack and of the breakpoint table.
  localparam int unsigned LAYER_DEPTH_DEF      = 64;
  localparam int unsigned BREAKPOINT_SLOTS_DEF = 16;

  // Field widths.
  localparam int unsigned CMD_W       = 4;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned EVENT_W     = 3;
  localparam int unsigned ORDER_W     = 2;
  localparam int unsigned RUN_W       = 4;
  localparam int unsigned DEPTH_OUT_W = 7;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ASK       = 4'd0;
  localparam logic [CMD_W-1:0] CMD_FLOW      = 4'd1;
  localparam logic [CMD_W-1:0] CMD_RUN       = 4'd2;
  localparam logic [CMD_W-1:0] CMD_STOP      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_STEP_OVER = 4'd4;
  localparam logic [CMD_W-1:0] CMD_STEP_INTO = 4'd5;
  localparam logic [CMD_W-1:0] CMD_STEP_OUT  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_HALT      = 4'd7;
  localparam logic [CMD_W-1:0] CMD_TOGGLE    = 4'd8;

  // Flow event codes.
  localparam logic [EVENT_W-1:0] EV_LINEAR         = 3'd0;
  localparam logic [EVENT_W-1:0] EV_CALL_ENTRY     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_CALL_RETURN    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_HANDLER_ENTRY  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_HANDLER_RETURN = 3'd4;

  // Order codes answered to an ask.
  localparam logic [ORDER_W-1:0] ORDER_WAIT = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_GO   = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_HALT = 2'd2;

  // Run states.
  localparam logic [RUN_W-1:0] RS_STOPPED   = 4'd0;
  localparam logic [RUN_W-1:0] RS_HALT_PEND = 4'd1;
  localparam logic [RUN_W-1:0] RS_RUN_PEND  = 4'd2;
  localparam logic [RUN_W-1:0] RS_RUNNING   = 4'd3;
  localparam logic [RUN_W-1:0] RS_OVER_PEND = 4'd4;
  localparam logic [RUN_W-1:0] RS_RUN_OVER  = 4'd5;
  localparam logic [RUN_W-1:0] RS_INTO_PEND = 4'd6;
  localparam logic [RUN_W-1:0] RS_RUN_INTO  = 4'd7;
  localparam logic [RUN_W-1:0] RS_OUT_PEND  = 4'd8;
  localparam logic [RUN_W-1:0] RS_RUN_OUT   = 4'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the request address
    logic execute;     // the execute cycle of a request
    logic ask;         // request is an ask
    logic push;        // push a layer
    logic pop;         // pop a layer
    logic tag;         // layer tag, 1 for handler
    logic toggle;      // toggle a breakpoint
    logic save_depth;  // copy the stack depth into the saved depth
  } dbgrc_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;         // address matches a valid breakpoint
    logic depth_zero;  // stack is empty
    logic depth_lt2;   // fewer than two layers
    logic tags_equal;  // two top layers carry the same tag
    logic out_stop;    // saved depth above current depth
    logic over_stop;   // saved depth equals current depth
  } dbgrc_status_t;

endpackage

@@ design/dbgrc_datapath.sv @@
`timescale 1ns / 1ps

module dbgrc_datapath #(
  parameter int unsigned LAYER_DEPTH      = dbgrc_pkg::LAYER_DEPTH_DEF,
  parameter int unsigned BREAKPOINT_SLOTS = dbgrc_pkg::BREAKPOINT_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [dbgrc_pkg::ADDR_W-1:0]      address_i,
  input  dbgrc_pkg::dbgrc_ctrl_t            ctrl_i,
  output dbgrc_pkg::dbgrc_status_t          status_o,
  output logic [dbgrc_pkg::DEPTH_OUT_W-1:0] layer_depth_o,
  output logic                              breakpoint_hit_o,
  output logic                              layer_error_o,
  output logic                              table_full_o
);

  localparam int unsigned DEPTH_W = $clog2(LAYER_DEPTH + 1);
  localparam int unsigned IDX_W   = $clog2(LAYER_DEPTH);
  localparam int unsigned OUT_W   = dbgrc_pkg::DEPTH_OUT_W;
  localparam int unsigned SLOTS   = BREAKPOINT_SLOTS;

  logic [dbgrc_pkg::ADDR_W-1:0] addr_q;
  logic [DEPTH_W-1:0]           depth_q, depth_d;
  logic [DEPTH_W-1:0]           saved_q, saved_d;
  logic                         tag_mem [LAYER_DEPTH];
  logic                         top_tag_q, next_tag_q;
  logic [IDX_W-1:0]             top_idx, next_idx, wr_idx;
  logic                         stack_full, push_ok, pop_ok, layer_err;
  logic [SLOTS-1:0]             bp_valid_q, bp_valid_d;
  logic [dbgrc_pkg::ADDR_W-1:0] bp_addr_q [SLOTS];
  logic [SLOTS-1:0]             match_vec, free_vec, first_free;
  logic                         any_match, no_free;
  logic                         hit_q, err_q, full_q;

  // Request address, held for the execute cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      addr_q <= address_i;
    end
  end

  // Stack addressing: the top two entries and the next free entry.
  always_comb begin
    top_idx    = (depth_q == '0) ? '0 : IDX_W'(depth_q - DEPTH_W'(1));
    next_idx   = (depth_q < DEPTH_W'(2)) ? '0 : IDX_W'(depth_q - DEPTH_W'(2));
    wr_idx     = IDX_W'(depth_q);
    stack_full = (depth_q >= DEPTH_W'(LAYER_DEPTH));
  end

  // Layer tag memory with registered reads of the two top entries.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      tag_mem[wr_idx] <= ctrl_i.tag;
    end
    top_tag_q  <= tag_mem[top_idx];
    next_tag_q <= tag_mem[next_idx];
  end

  // Push and pop checks; a failed one leaves the stack alone.
  always_comb begin
    push_ok   = ctrl_i.push && !stack_full;
    pop_ok    = ctrl_i.pop && (depth_q != '0) && (top_tag_q == ctrl_i.tag);
    layer_err = (ctrl_i.push && !push_ok) || (ctrl_i.pop && !pop_ok);
    depth_d   = depth_q;
    if (push_ok) begin
      depth_d = depth_q + DEPTH_W'(1);
    end else if (pop_ok) begin
      depth_d = depth_q - DEPTH_W'(1);
    end
    saved_d = ctrl_i.save_depth ? depth_q : saved_q;
  end

  // Breakpoint comparators, one per slot.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = bp_valid_q[i] && (bp_addr_q[i] == addr_q);
    end
    free_vec   = ~bp_valid_q;
    first_free = free_vec & (~free_vec + SLOTS'(1));
    any_match  = |match_vec;
    no_free    = ~|free_vec;
  end

  // Toggle: remove a matching entry, otherwise take the lowest free slot.
  always_comb begin
    bp_valid_d = bp_valid_q;
    if (ctrl_i.toggle) begin
      if (any_match) begin
        bp_valid_d = bp_valid_q & ~match_vec;
      end else begin
        bp_valid_d = bp_valid_q | first_free;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (ctrl_i.toggle && !any_match && first_free[i]) begin
        bp_addr_q[i] <= addr_q;
      end
    end
  end

  // Stack depth, saved depth, valid bits and result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= '0;
      saved_q    <= '0;
      bp_valid_q <= '0;
      hit_q      <= 1'b0;
      err_q      <= 1'b0;
      full_q     <= 1'b0;
    end else begin
      depth_q    <= depth_d;
      saved_q    <= saved_d;
      bp_valid_q <= bp_valid_d;
      if (ctrl_i.execute) begin
        hit_q  <= ctrl_i.ask && any_match;
        err_q  <= layer_err;
        full_q <= ctrl_i.toggle && !any_match && no_free;
      end
    end
  end

  // Status for the run state machine.
  always_comb begin
    status_o.hit        = any_match;
    status_o.depth_zero = (depth_q == '0);
    status_o.depth_lt2  = (depth_q < DEPTH_W'(2));
    status_o.tags_equal = (top_tag_q == next_tag_q);
    status_o.out_stop   = (saved_q > depth_q);
    status_o.over_stop  = (saved_q == depth_q);
  end

  assign layer_depth_o    = OUT_W'(depth_q);
  assign breakpoint_hit_o = hit_q;
  assign layer_error_o    = err_q;
  assign table_full_o     = full_q;

endmodule

@@ design/dbgrc_ctrl.sv @@
`timescale 1ns / 1ps
`include "debug_run_control_defines.svh"

module dbgrc_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [dbgrc_pkg::CMD_W-1:0]        command_i,
  input  logic [dbgrc_pkg::EVENT_W-1:0]      flow_event_i,
  input  dbgrc_pkg::dbgrc_status_t           status_i,
  output dbgrc_pkg::dbgrc_ctrl_t             ctrl_o,
  output logic                               done_o,
  output logic [dbgrc_pkg::ORDER_W-1:0]      order_o,
  output logic [dbgrc_pkg::RUN_W-1:0]        run_state_o
);

  // Sequencer codes.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                            state_q, state_d;
  logic [dbgrc_pkg::CMD_W-1:0]     cmd_q;
  logic [dbgrc_pkg::EVENT_W-1:0]   ev_q;
  logic [dbgrc_pkg::RUN_W-1:0]     run_q, run_d;
  logic [dbgrc_pkg::ORDER_W-1:0]   order_q, order_d;
  logic                            done_q;
  logic                            accept, exec, busy_step, stop_now;
  logic                            dec_ask, dec_push, dec_pop, dec_tag, dec_toggle, dec_save;

  assign accept = start && (state_q == S_IDLE);
  assign exec   = (state_q == S_EXEC);
  assign busy   = (state_q != S_IDLE);

  // Sequencer: capture a request, then execute it in the next cycle.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Stop rule of the active run or step mode.
  always_comb begin
    stop_now = status_i.hit ||
               ((run_q == dbgrc_pkg::RS_RUN_INTO) &&
                (status_i.depth_lt2 || status_i.tags_equal)) ||
               ((run_q == dbgrc_pkg::RS_RUN_OUT) && status_i.out_stop) ||
               ((run_q == dbgrc_pkg::RS_RUN_OVER) &&
                (status_i.depth_zero || status_i.over_stop));
    busy_step = (run_q == dbgrc_pkg::RS_RUN_OUT) || (run_q == dbgrc_pkg::RS_RUN_OVER);
  end

  // Command decode and run state transitions.
  always_comb begin
    run_d      = run_q;
    order_d    = dbgrc_pkg::ORDER_WAIT;
    dec_ask    = 1'b0;
    dec_push   = 1'b0;
    dec_pop    = 1'b0;
    dec_tag    = 1'b0;
    dec_toggle = 1'b0;
    dec_save   = 1'b0;
    case (cmd_q)
      dbgrc_pkg::CMD_ASK: begin
        dec_ask = 1'b1;
        case (run_q)
          dbgrc_pkg::RS_HALT_PEND: begin
            order_d = dbgrc_pkg::ORDER_HALT;
          end
          dbgrc_pkg::RS_RUN_PEND: begin
            run_d   = dbgrc_pkg::RS_RUNNING;
            order_d = dbgrc_pkg::ORDER_GO;
          end
          dbgrc_pkg::RS_INTO_PEND: begin
            dec_save = 1'b1;
            run_d    = dbgrc_pkg::RS_RUN_INTO;
            order_d  = dbgrc_pkg::ORDER_GO;
          end
          dbgrc_pkg::RS_OUT_PEND: begin
            dec_save = 1'b1;
            run_d    = dbgrc_pkg::RS_RUN_OUT;
            order_d  = dbgrc_pkg::ORDER_GO;
          end
          dbgrc_pkg::RS_OVER_PEND: begin
            dec_save = 1'b1;
            run_d    = dbgrc_pkg::RS_RUN_OVER;
            order_d  = dbgrc_pkg::ORDER_GO;
          end
          dbgrc_pkg::RS_RUNNING, dbgrc_pkg::RS_RUN_INTO,
          dbgrc_pkg::RS_RUN_OUT, dbgrc_pkg::RS_RUN_OVER: begin
            if (stop_now) begin
              run_d   = dbgrc_pkg::RS_STOPPED;
              order_d = dbgrc_pkg::ORDER_WAIT;
            end else begin
              order_d = dbgrc_pkg::ORDER_GO;
            end
          end
          default: begin
            order_d = dbgrc_pkg::ORDER_WAIT;
          end
        endcase
      end
      dbgrc_pkg::CMD_FLOW: begin
        case (ev_q)
          dbgrc_pkg::EV_CALL_ENTRY: begin
            dec_push = 1'b1;
          end
          dbgrc_pkg::EV_CALL_RETURN: begin
            dec_pop = 1'b1;
          end
          dbgrc_pkg::EV_HANDLER_ENTRY: begin
            dec_push = 1'b1;
            dec_tag  = 1'b1;
          end
          dbgrc_pkg::EV_HANDLER_RETURN: begin
            dec_pop = 1'b1;
            dec_tag = 1'b1;
          end
          default: begin
            dec_push = 1'b0;
          end
        endcase
      end
      dbgrc_pkg::CMD_RUN: begin
        if ((run_q != dbgrc_pkg::RS_RUNNING) && !busy_step) begin
          run_d = dbgrc_pkg::RS_RUN_PEND;
        end
      end
      dbgrc_pkg::CMD_STOP: begin
        if (run_q == dbgrc_pkg::RS_RUNNING) begin
          run_d = dbgrc_pkg::RS_STOPPED;
        end
      end
      dbgrc_pkg::CMD_STEP_OVER: begin
        if (!busy_step) begin
          run_d = dbgrc_pkg::RS_OVER_PEND;
        end
      end
      dbgrc_pkg::CMD_STEP_INTO: begin
        if (!busy_step) begin
          run_d = dbgrc_pkg::RS_INTO_PEND;
        end
      end
      dbgrc_pkg::CMD_STEP_OUT: begin
        if (!busy_step && !status_i.depth_zero) begin
          run_d = dbgrc_pkg::RS_OUT_PEND;
        end
      end
      dbgrc_pkg::CMD_HALT: begin
        run_d = dbgrc_pkg::RS_HALT_PEND;
      end
      dbgrc_pkg::CMD_TOGGLE: begin
        dec_toggle = 1'b1;
      end
      default: begin
        run_d = run_q;
      end
    endcase
  end

  // Datapath commands: capture on accept, tag from the decode, the rest only in the execute cycle.
  always_comb begin
    ctrl_o.capture    = accept;
    ctrl_o.execute    = exec;
    ctrl_o.ask        = exec && dec_ask;
    ctrl_o.push       = exec && dec_push;
    ctrl_o.pop        = exec && dec_pop;
    ctrl_o.tag        = dec_tag;
    ctrl_o.toggle     = exec && dec_toggle;
    ctrl_o.save_depth = exec && dec_save;
  end

  // Request fields held for the execute cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      ev_q  <= flow_event_i;
    end
  end

  // Sequencer state, run state and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      run_q   <= dbgrc_pkg::RS_STOPPED;
      order_q <= dbgrc_pkg::ORDER_WAIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= exec;
      if (exec) begin
        run_q   <= run_d;
        order_q <= order_d;
      end
    end
  end

  assign done_o      = done_q;
  assign order_o     = order_q;
  assign run_state_o = run_q;

  // Every accepted request is answered by done_q after its execute cycle.
  `DBGRC_ASSERT_NOW(a_accept_answered, accept, ##2 done_q)
  // A result is never shown while a request is in execution.
  `DBGRC_ASSERT_NOW(a_done_when_idle, done_q, state_q == S_IDLE)
  // An ask during halt pending answers halt and keeps the state.
  `DBGRC_ASSERT_NEXT(a_halt_pend_holds,
    exec && (cmd_q == dbgrc_pkg::CMD_ASK) && (run_q == dbgrc_pkg::RS_HALT_PEND),
    (run_q == dbgrc_pkg::RS_HALT_PEND) && (order_q == dbgrc_pkg::ORDER_HALT))

endmodule

@@ design/debug_run_control.sv @@
`timescale 1ns / 1ps
// Channel   Handshake         Fields
// request   start / busy      command_i, address_i, flow_event_i
// result    done_o (strobe)   order_o, run_state_o, layer_depth_o, breakpoint_hit_o,
//                             layer_error_o, table_full_o
//
// A request is taken when start is high and busy is low; busy then stays high for
// one cycle while the two top layer tags come out of the registered stack memory.
// The request executes in that cycle and its result is shown in the cycle after, for
// one cycle under done_o; a new request can be taken while that result is shown.
// Reset clears the run state, stack depth, saved depth and breakpoint valid bits at
// once; there is no clearing pass. The receiver cannot stall the results.

module debug_run_control #(
  parameter int unsigned LAYER_DEPTH      = dbgrc_pkg::LAYER_DEPTH_DEF,
  parameter int unsigned BREAKPOINT_SLOTS = dbgrc_pkg::BREAKPOINT_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [dbgrc_pkg::CMD_W-1:0]       command_i,
  input  logic [dbgrc_pkg::ADDR_W-1:0]      address_i,
  input  logic [dbgrc_pkg::EVENT_W-1:0]     flow_event_i,
  output logic                              done_o,
  output logic [dbgrc_pkg::ORDER_W-1:0]     order_o,
  output logic [dbgrc_pkg::RUN_W-1:0]       run_state_o,
  output logic [dbgrc_pkg::DEPTH_OUT_W-1:0] layer_depth_o,
  output logic                              breakpoint_hit_o,
  output logic                              layer_error_o,
  output logic                              table_full_o
);

  dbgrc_pkg::dbgrc_ctrl_t   ctrl;
  dbgrc_pkg::dbgrc_status_t status;

  // Sequencer and run state machine.
  dbgrc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .flow_event_i (flow_event_i),
    .status_i     (status),
    .ctrl_o       (ctrl),
    .done_o       (done_o),
    .order_o      (order_o),
    .run_state_o  (run_state_o)
  );

  // Layer stack, breakpoint table and result flags.
  dbgrc_datapath #(
    .LAYER_DEPTH      (LAYER_DEPTH),
    .BREAKPOINT_SLOTS (BREAKPOINT_SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .address_i        (address_i),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .layer_depth_o    (layer_depth_o),
    .breakpoint_hit_o (breakpoint_hit_o),
    .layer_error_o    (layer_error_o),
    .table_full_o     (table_full_o)
  );

endmodule
